// ----- design/binary_erosion_cross_3x3_macros.svh -----
`ifndef BINARY_EROSION_CROSS_3X3_MACROS_SVH
`define BINARY_EROSION_CROSS_3X3_MACROS_SVH

// same-cycle implication
`define BEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bec: same-cycle check failed");

// next-cycle implication
`define BEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bec: next-cycle check failed");

`endif

// ----- design/bec_pkg.sv -----
package bec_pkg;

  localparam int CFG_W          = 11;
  localparam int PIX_W          = 8;
  localparam int OUT_POS_W      = 10;
  localparam int CFG_IDX_W      = 1;
  localparam int MIN_DIM        = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd950;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd950;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // control of one window cell
  typedef struct packed {
    logic shift;  // advance the window by one column
    logic load;   // show the direct value instead of the stored one
  } cell_ctrl_t;

endpackage

// ----- design/bec_cell.sv -----
module bec_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bec_pkg::cell_ctrl_t ctrl_i,
  input  logic                load_bit_i,
  input  logic                shift_in_i,
  output logic                bit_o
);

  logic bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      bit_q <= shift_in_i;
    end
  end

  assign bit_o = ctrl_i.load ? load_bit_i : bit_q;

endmodule

// ----- design/bec_line_store.sv -----
module bec_line_store #(
  parameter int MAX_WIDTH = bec_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col_i,
  input  logic                         cur_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col_i,
  input  logic                         wr_bit_i,
  output logic                         mid_o,
  output logic                         right_o,
  output logic                         up_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic          newer_mem [MAX_WIDTH];
  logic          older_mem [MAX_WIDTH];
  logic          mid_q;
  logic          right_q;
  logic          up_q;
  logic [CW-1:0] right_col;

  // the column after the last one never reaches the result (border), park it at 0
  assign right_col = (rd_col_i == CW'(MAX_WIDTH - 1)) ? '0 : rd_col_i + CW'(1);

  // row r-1: read old contents, then overwrite with the current row
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mid_q              <= newer_mem[rd_col_i];
      right_q            <= newer_mem[right_col];
      newer_mem[rd_col_i] <= cur_i;
    end
  end

  // row r-2
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_q <= older_mem[rd_col_i];
    end
    if (wr_en_i) begin
      older_mem[wr_col_i] <= wr_bit_i;
    end
  end

  assign mid_o   = mid_q;
  assign right_o = right_q;
  assign up_o    = up_q;

endmodule

// ----- design/binary_erosion_cross_3x3.sv -----
// Binary 3x3 cross erosion on a raster pixel stream. One pixel is accepted per clock while the
// window stage is not held by the output; pixel (r,c) produces the result for (r-1,c), the first
// row produces nothing and every pixel of the last row produces a second, zero result for
// itself, so on the last row the single output port slows the input. With the output register
// free, the first result of a pixel is loaded into it in the cycle after the pixel is accepted,
// and the second result follows it. The two previous rows live in two MAX_WIDTH x 1 line
// stores that are not cleared after reset; the centre row is walked through a chain of two
// window cells. image_width and image_height are clamped to 3..MAX and may only be written
// while no transaction is in flight.
`include "binary_erosion_cross_3x3_macros.svh"

module binary_erosion_cross_3x3 #(
  parameter int MAX_WIDTH  = bec_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bec_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bec_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bec_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bec_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            eroded_pixel_o,
  output logic [bec_pkg::OUT_POS_W-1:0]   out_row_o,
  output logic [bec_pkg::OUT_POS_W-1:0]   out_col_o,
  output logic                            run_last_o,
  output logic                            image_end_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WDW  = $clog2(MAX_WIDTH + 1);
  localparam int HDW  = $clog2(MAX_HEIGHT + 1);
  localparam int OPW  = bec_pkg::OUT_POS_W;
  localparam int CFGW = bec_pkg::CFG_W;

  // configuration
  logic [CFGW-1:0] img_w_q;
  logic [CFGW-1:0] img_h_q;
  logic [WDW-1:0]  w_eff;
  logic [HDW-1:0]  h_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= bec_pkg::IMAGE_WIDTH_RST;
      img_h_q <= bec_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bec_pkg::cfg_reg_e'(cfg_index_i))
        bec_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i;
        bec_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(img_w_q) < bec_pkg::MIN_DIM) begin
      w_eff = WDW'(bec_pkg::MIN_DIM);
    end else if (32'(img_w_q) > MAX_WIDTH) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = WDW'(img_w_q);
    end
    if (32'(img_h_q) < bec_pkg::MIN_DIM) begin
      h_eff = HDW'(bec_pkg::MIN_DIM);
    end else if (32'(img_h_q) > MAX_HEIGHT) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = HDW'(img_h_q);
    end
  end

  // position counters and per-pixel flags
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          in_acc;
  logic          cur_in;
  logic          last_col_in;
  logic          last_row_in;
  logic          border_in;
  logic          has_up_in;

  assign in_acc      = in_valid_i && in_ready_o;
  assign cur_in      = pixel_value_i != '0;
  assign last_col_in = (WDW'(col_q) + WDW'(1)) >= w_eff;
  assign last_row_in = (HDW'(row_q) + HDW'(1)) >= h_eff;
  assign has_up_in   = row_q != '0;
  // result row r-1 on the top or bottom border, or column on the left or right border
  assign border_in   = (row_q == RW'(1)) || (HDW'(row_q) >= h_eff) ||
                       (col_q == '0) || last_col_in;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (last_col_in) begin
        col_d = '0;
        row_d = last_row_in ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // window stage
  logic          s1_valid_q;
  logic          s1_phase_q;
  logic          s1_cur_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic          s1_has_up_q;
  logic          s1_last_row_q;
  logic          s1_last_col_q;
  logic          s1_border_q;
  logic          s1_has_res;
  logic          s1_second;
  logic          s1_final;
  logic          out_free;
  logic          emit;
  logic          consume;

  logic          out_valid_q;

  assign s1_has_res = s1_has_up_q || s1_last_row_q;
  assign s1_second  = s1_phase_q || !s1_has_up_q;
  assign s1_final   = s1_second || !s1_last_row_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = s1_valid_q && s1_has_res && out_free;
  assign consume    = s1_valid_q && (!s1_has_res || (emit && s1_final));
  assign in_ready_o = !s1_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_phase_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (consume) begin
        s1_valid_q <= 1'b0;
      end
      if (consume) begin
        s1_phase_q <= 1'b0;
      end else if (emit) begin
        s1_phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cur_q      <= cur_in;
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_has_up_q   <= has_up_in;
      s1_last_row_q <= last_row_in;
      s1_last_col_q <= last_col_in;
      s1_border_q   <= border_in;
    end
  end

  // line stores and window chain (row r-1: left, centre, right)
  logic                mid_rd;
  logic                right_rd;
  logic                up_rd;
  logic                mid;
  logic                left;
  bec_pkg::cell_ctrl_t centre_ctrl;
  bec_pkg::cell_ctrl_t left_ctrl;

  bec_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i    (clk_i),
    .rd_en_i  (in_acc),
    .rd_col_i (col_q),
    .cur_i    (cur_in),
    .wr_en_i  (consume),
    .wr_col_i (s1_col_q),
    .wr_bit_i (mid),
    .mid_o    (mid_rd),
    .right_o  (right_rd),
    .up_o     (up_rd)
  );

  // at the start of a row the centre comes straight from the store
  assign centre_ctrl = '{shift: consume, load: (s1_col_q == '0)};
  assign left_ctrl   = '{shift: consume, load: 1'b0};

  bec_cell u_cell_centre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (centre_ctrl),
    .load_bit_i (mid_rd),
    .shift_in_i (right_rd),
    .bit_o      (mid)
  );

  bec_cell u_cell_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (left_ctrl),
    .load_bit_i (1'b0),
    .shift_in_i (mid),
    .bit_o      (left)
  );

  // result selection
  logic           val;
  logic           res_pixel;
  logic [RW-1:0]  res_row;
  logic           res_last;
  logic           res_end;
  logic           eroded_q;
  logic [OPW-1:0] out_row_q;
  logic [OPW-1:0] out_col_q;
  logic           run_last_q;
  logic           image_end_q;

  assign val = !s1_border_q && mid && up_rd && s1_cur_q && left && right_rd;

  always_comb begin
    if (!s1_second) begin
      res_pixel = val;
      res_row   = s1_row_q - RW'(1);
      res_last  = !s1_last_row_q;
      res_end   = 1'b0;
    end else begin
      // own result of a last-row pixel, always on the border
      res_pixel = 1'b0;
      res_row   = s1_row_q;
      res_last  = 1'b1;
      res_end   = s1_last_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      eroded_q    <= res_pixel;
      out_row_q   <= OPW'(res_row);
      out_col_q   <= OPW'(s1_col_q);
      run_last_q  <= res_last;
      image_end_q <= res_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign eroded_pixel_o = eroded_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign run_last_o     = run_last_q;
  assign image_end_o    = image_end_q;

  `BEC_ASSERT_IMPL(a_end_on_last, clk_i, rst_ni, out_valid_o && image_end_o, run_last_o)
  `BEC_ASSERT_IMPL(a_col0_border, clk_i, rst_ni, out_valid_o && (out_col_o == '0), !eroded_pixel_o)
  `BEC_ASSERT_NEXT(a_second_result, clk_i, rst_ni, emit && !s1_final, s1_valid_q && s1_phase_q)
  `BEC_ASSERT_NEXT(a_col_step, clk_i, rst_ni, in_acc && !last_col_in, col_q == $past(col_q) + CW'(1))

endmodule
